// ----- rtl/jtbr_pkg.sv -----
// jtbr_pkg: shared widths and the control type of the compare unit
// for the joint tree breadth-first reorder block; depends on nothing
package jtbr_pkg;

  // fixed widths of the request and result fields
  localparam int PW = 6;
  localparam int OW = 6;

  // control of the shared compare unit
  typedef struct packed {
    logic en;         // stored parent word is valid this cycle
    logic root_mode;  // 1: test for self-parent, 0: test for child of key
  } jtbr_cmp_ctl_t;

endpackage

// ----- rtl/joint_tree_bfs_reorder.sv -----
// joint_tree_bfs_reorder: top level, sequencer, visited marks and result register
// depends on jtbr_pkg, jtbr_mem (parent store and queue) and jtbr_match
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid in_stall in_parent_index in_last_joint | into block
//  out     | out_valid out_stall out_origin_index           | out of block
//          | out_new_parent out_malformed out_last_result   |
//
// Loading stores one joint per accepted request; the request carrying last_joint starts the
// reorder, and no request is taken until the last result has been loaded.
// For every joint reached from a root, its children are found by a scan through
// the single read port of the parent store over all stored joints. Each root
// candidate is read and then checked, and a final scan emits the unreachable joints.
// Reset is synchronous and active low; it clears control state and the marks.
// A stall on the result side only holds the sequencer where a result is due.
module joint_tree_bfs_reorder import jtbr_pkg::*; #(
  parameter int MAX_JOINTS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [PW-1:0] in_parent_index,
  input  logic          in_last_joint,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [OW-1:0] out_origin_index,
  output logic [OW-1:0] out_new_parent,
  output logic          out_malformed,
  output logic          out_last_result
);

  localparam int IW = $clog2(MAX_JOINTS);
  localparam int CW = $clog2(MAX_JOINTS + 1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_ROOT_RD = 7'b0000010,
    S_ROOT_CK = 7'b0000100,
    S_Q_RD    = 7'b0001000,
    S_Q_OUT   = 7'b0010000,
    S_SCAN    = 7'b0100000,
    S_MAL     = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           head_r, head_nxt;
  logic [CW-1:0]           tail_r, tail_nxt;
  logic [CW-1:0]           emit_r, emit_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           scan_r, scan_nxt;
  logic                    chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]           chk_idx_r, chk_idx_nxt;
  logic [IW-1:0]           cur_org_r, cur_org_nxt;
  logic [IW-1:0]           here_r, here_nxt;
  logic [MAX_JOINTS-1:0]   visited_r, visited_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OW-1:0]           out_org_r, out_org_nxt;
  logic [OW-1:0]           out_par_r, out_par_nxt;
  logic                    out_mal_r, out_mal_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    in_acc;
  logic                    out_free;
  logic                    is_final;
  logic                    ps_we;
  logic                    ps_re;
  logic [IW-1:0]           ps_raddr;
  logic [PW-1:0]           ps_rdata;
  logic                    q_re;
  logic [2*IW-1:0]         q_rdata;
  logic                    push_en;
  logic [IW-1:0]           push_org;
  logic [IW-1:0]           push_pos;
  jtbr_cmp_ctl_t           cmp_ctl;
  logic [IW-1:0]           cmp_idx;
  logic                    cmp_hit;

  // handshake
  assign in_stall = !(state_r == S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign is_final = (CW'(emit_r + 1'b1) == count_r);
  assign ps_we    = in_acc && (count_r < CW'(MAX_JOINTS));

  // parent store
  jtbr_mem #(.W(PW), .D(MAX_JOINTS)) u_pstore (
    .clk   (clk),
    .we    (ps_we),
    .waddr (count_r[IW-1:0]),
    .wdata (in_parent_index),
    .re    (ps_re),
    .raddr (ps_raddr),
    .rdata (ps_rdata)
  );

  // breadth-first queue, origin in the upper half, parent position below
  jtbr_mem #(.W(2*IW), .D(MAX_JOINTS)) u_queue (
    .clk   (clk),
    .we    (push_en),
    .waddr (tail_r[IW-1:0]),
    .wdata ({push_org, push_pos}),
    .re    (q_re),
    .raddr (head_r[IW-1:0]),
    .rdata (q_rdata)
  );

  // shared compare unit
  assign cmp_ctl.en        = (state_r == S_ROOT_CK) || ((state_r == S_SCAN) && chk_vld_r);
  assign cmp_ctl.root_mode = (state_r == S_ROOT_CK);
  assign cmp_idx           = (state_r == S_ROOT_CK) ? idx_r[IW-1:0] : chk_idx_r;

  jtbr_match #(.IW(IW)) u_match (
    .ctl    (cmp_ctl),
    .parent (ps_rdata),
    .idx    (cmp_idx),
    .key    (cur_org_r),
    .hit    (cmp_hit)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    emit_nxt      = emit_r;
    idx_nxt       = idx_r;
    scan_nxt      = scan_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    cur_org_nxt   = cur_org_r;
    here_nxt      = here_r;
    visited_nxt   = visited_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_org_nxt   = out_org_r;
    out_par_nxt   = out_par_r;
    out_mal_nxt   = out_mal_r;
    out_last_nxt  = out_last_r;
    ps_re         = 1'b0;
    ps_raddr      = idx_r[IW-1:0];
    q_re          = 1'b0;
    push_en       = 1'b0;
    push_org      = cmp_idx;
    push_pos      = here_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (ps_we) begin
            count_nxt = CW'(count_r + 1'b1);
          end
          if (in_last_joint) begin
            visited_nxt = '0;
            head_nxt    = '0;
            tail_nxt    = '0;
            emit_nxt    = '0;
            idx_nxt     = '0;
            state_nxt   = S_ROOT_RD;
          end
        end
      end
      // next root candidate
      S_ROOT_RD: begin
        if (idx_r == count_r) begin
          idx_nxt   = '0;
          state_nxt = S_MAL;
        end else begin
          ps_re     = 1'b1;
          state_nxt = S_ROOT_CK;
        end
      end
      S_ROOT_CK: begin
        idx_nxt = CW'(idx_r + 1'b1);
        if (cmp_hit && !visited_r[idx_r[IW-1:0]]) begin
          push_en   = 1'b1;
          push_pos  = emit_r[IW-1:0];
          state_nxt = S_Q_RD;
        end else begin
          state_nxt = S_ROOT_RD;
        end
      end
      // dequeue, or resume the root scan when the tree is done
      S_Q_RD: begin
        if (head_r == tail_r) begin
          state_nxt = S_ROOT_RD;
        end else begin
          q_re      = 1'b1;
          state_nxt = S_Q_OUT;
        end
      end
      S_Q_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_org_nxt   = OW'(q_rdata[2*IW-1:IW]);
          out_par_nxt   = OW'(q_rdata[IW-1:0]);
          out_mal_nxt   = 1'b0;
          out_last_nxt  = is_final;
          cur_org_nxt   = q_rdata[2*IW-1:IW];
          here_nxt      = emit_r[IW-1:0];
          emit_nxt      = CW'(emit_r + 1'b1);
          head_nxt      = CW'(head_r + 1'b1);
          scan_nxt      = '0;
          state_nxt     = S_SCAN;
        end
      end
      // child scan: read one stored parent a cycle, compare it in the cycle after
      S_SCAN: begin
        if (scan_r != count_r) begin
          ps_re       = 1'b1;
          ps_raddr    = scan_r[IW-1:0];
          scan_nxt    = CW'(scan_r + 1'b1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_r[IW-1:0];
        end else if (!chk_vld_r) begin
          state_nxt = S_Q_RD;
        end
        if (cmp_hit && !visited_r[chk_idx_r]) begin
          push_en = 1'b1;
        end
      end
      // unreachable joints, self-parented
      S_MAL: begin
        if (idx_r == count_r) begin
          count_nxt = '0;
          state_nxt = S_IDLE;
        end else if (visited_r[idx_r[IW-1:0]]) begin
          idx_nxt = CW'(idx_r + 1'b1);
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_org_nxt   = OW'(idx_r);
          out_par_nxt   = OW'(emit_r);
          out_mal_nxt   = 1'b1;
          out_last_nxt  = is_final;
          emit_nxt      = CW'(emit_r + 1'b1);
          idx_nxt       = CW'(idx_r + 1'b1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // enqueue marks the joint as visited
    if (push_en) begin
      visited_nxt[push_org] = 1'b1;
      tail_nxt              = CW'(tail_r + 1'b1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      emit_r      <= '0;
      idx_r       <= '0;
      scan_r      <= '0;
      chk_vld_r   <= 1'b0;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      emit_r      <= emit_nxt;
      idx_r       <= idx_nxt;
      scan_r      <= scan_nxt;
      chk_vld_r   <= chk_vld_nxt;
      visited_r   <= visited_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    chk_idx_r  <= chk_idx_nxt;
    cur_org_r  <= cur_org_nxt;
    here_r     <= here_nxt;
    out_org_r  <= out_org_nxt;
    out_par_r  <= out_par_nxt;
    out_mal_r  <= out_mal_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_origin_index = out_org_r;
  assign out_new_parent   = out_par_r;
  assign out_malformed    = out_mal_r;
  assign out_last_result  = out_last_r;

  // checks
  a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (head_r <= tail_r))
    else $error("queue head ran past tail");

  a_tail_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (tail_r <= count_r))
    else $error("more joints queued than stored");

  a_queue_empty_at_mal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT_RD && idx_r == count_r) |-> (head_r == tail_r))
    else $error("root scan ended with joints still queued");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (emit_r <= count_r))
    else $error("more results than stored joints");

endmodule

// ----- rtl/jtbr_mem.sv -----
// jtbr_mem: simple dual-port memory, one write and one registered read
// no package use; instantiated twice by the top level
module jtbr_mem #(
  parameter int W = 6,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_q[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/jtbr_match.sv -----
// jtbr_match: shared compare unit used by the root scan and the child scan
// depends on jtbr_pkg for the field width and the control struct
module jtbr_match import jtbr_pkg::*; #(
  parameter int IW = 6
) (
  input  jtbr_cmp_ctl_t ctl,
  input  logic [PW-1:0] parent,
  input  logic [IW-1:0] idx,
  input  logic [IW-1:0] key,
  output logic          hit
);

  localparam int CMPW = (IW > PW) ? IW : PW;

  logic [CMPW-1:0] par_x;
  logic [CMPW-1:0] idx_x;
  logic [CMPW-1:0] key_x;
  logic            self_par;

  // widen both sides to a common width
  assign par_x    = CMPW'(parent);
  assign idx_x    = CMPW'(idx);
  assign key_x    = CMPW'(key);
  assign self_par = (par_x == idx_x);

  // root: parent is itself; child: not a root and parent is the key
  always_comb begin
    hit = 1'b0;
    if (ctl.en) begin
      if (ctl.root_mode) begin
        hit = self_par;
      end else begin
        hit = !self_par && (par_x == key_x);
      end
    end
  end

endmodule
